@@ sv/u8u16_pkg.sv @@
// Shared types, constants and helper functions of the UTF-8 to UTF-16 decoder.
`default_nettype none
package u8u16_pkg;

  localparam int unsigned UnitW = 16;
  localparam int unsigned LenW  = 3;

  localparam logic [15:0] Replacement = 16'hFFFD;
  localparam logic [31:0] MaxBmp      = 32'h0000_FFFF;
  localparam logic [31:0] MaxCode     = 32'h0010_FFFF;
  localparam logic [19:0] SuppBase    = 20'h1_0000;
  localparam logic [15:0] HighSurr    = 16'hD800;
  localparam logic [15:0] LowSurr     = 16'hDC00;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_TRUNC   = 2'd2
  } status_t;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic [1:0]       status;
    logic [LenW-1:0]  bad_length;
    logic             last_of_run;
  } result_t;

  // Up to two results made by one input byte.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic result_t make_result(logic [UnitW-1:0] unit, status_t st,
                                          logic [LenW-1:0] blen, logic last);
    result_t r;
    r.code_unit   = unit;
    r.status      = st;
    r.bad_length  = blen;
    r.last_of_run = last;
    return r;
  endfunction

  // Sequence length announced by a lead byte; 0 means not a valid lead.
  function automatic logic [LenW-1:0] lead_length(logic [7:0] b);
    logic [LenW-1:0] len;
    priority casez (b)
      8'b0???_????: len = 3'd1;
      8'b10??_????: len = 3'd0;
      8'b110?_????: len = 3'd2;
      8'b1110_????: len = 3'd3;
      8'b1111_0???: len = 3'd4;
      8'b1111_10??: len = 3'd5;
      8'b1111_110?: len = 3'd6;
      default:      len = 3'd0;
    endcase
    return len;
  endfunction

  // Sum of the lead and trail marker bits for each sequence length.
  function automatic logic [31:0] seq_offset(logic [LenW-1:0] len);
    logic [31:0] off;
    unique case (len)
      3'd2:        off = 32'h0000_3080;
      3'd3:        off = 32'h000E_2080;
      3'd4:        off = 32'h03C8_2080;
      3'd5:        off = 32'hFA08_2080;
      3'd6, 3'd7:  off = 32'h8208_2080;
      default:     off = 32'h0000_0000;
    endcase
    return off;
  endfunction

endpackage
`default_nettype wire

@@ sv/u8u16_if.sv @@
// Valid/ready channel interfaces for input bytes and output code units.
`default_nettype none
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_in_stream;

  modport source (output valid, output byte_value, output last_in_stream, input ready);
  modport sink (input valid, input byte_value, input last_in_stream, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [1:0]  status;
  logic [2:0]  bad_length;
  logic        last_of_run;

  modport source (output valid, output code_unit, output status, output bad_length,
                  output last_of_run, input ready);
  modport sink (input valid, input code_unit, input status, input bad_length,
                input last_of_run, output ready);
endinterface
`default_nettype wire

@@ sv/u8u16_decode.sv @@
// Sequence state and per-byte decode into zero, one or two code units.
`default_nettype none
module u8u16_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          byte_value,
  input  logic                last_in_stream,
  output u8u16_pkg::push_t    push
);
  import u8u16_pkg::*;

  logic [LenW-1:0] expected_length, expected_length_next;
  logic [LenW-1:0] bytes_seen, bytes_seen_next;
  logic [31:0]     accumulator, accumulator_next;

  logic [31:0]     acc_shift;
  logic [LenW-1:0] seen_inc;
  logic [31:0]     ch;
  logic [19:0]     supp;
  logic [LenW-1:0] lead;
  push_t           res;

  assign acc_shift = {accumulator[25:0], 6'b0} + {24'b0, byte_value};
  assign seen_inc  = bytes_seen + 3'd1;
  assign ch        = acc_shift - seq_offset(expected_length);
  assign supp      = ch[19:0] - SuppBase;
  assign lead      = lead_length(byte_value);

  always_comb begin
    expected_length_next = expected_length;
    bytes_seen_next      = bytes_seen;
    accumulator_next     = accumulator;
    res                  = '0;
    if (expected_length == 3'd0) begin
      priority if (lead == 3'd1) begin
        res.count = 2'd1;
        res.first = make_result({8'h00, byte_value}, ST_OK, 3'd0, 1'b1);
      end else if (lead == 3'd0) begin
        res.count = 2'd1;
        res.first = make_result(Replacement, ST_ILLEGAL, 3'd1, 1'b1);
      end else if (last_in_stream) begin
        res.count = 2'd1;
        res.first = make_result(Replacement, ST_TRUNC, 3'd0, 1'b1);
      end else begin
        expected_length_next = lead;
        bytes_seen_next      = 3'd1;
        accumulator_next     = {24'b0, byte_value};
      end
    end else if (byte_value[7:6] != 2'b10) begin
      expected_length_next = '0;
      bytes_seen_next      = '0;
      accumulator_next     = '0;
      res.count            = 2'd1;
      res.first            = make_result(Replacement, ST_ILLEGAL, bytes_seen, 1'b1);
    end else if (seen_inc >= expected_length) begin
      expected_length_next = '0;
      bytes_seen_next      = '0;
      accumulator_next     = '0;
      priority if (ch > MaxCode) begin
        res.count = 2'd1;
        res.first = make_result(Replacement, ST_ILLEGAL, expected_length, 1'b1);
      end else if (ch <= MaxBmp) begin
        res.count = 2'd1;
        res.first = make_result(ch[15:0], ST_OK, 3'd0, 1'b1);
      end else begin
        res.count  = 2'd2;
        res.first  = make_result({6'b0, supp[19:10]} + HighSurr, ST_OK, 3'd0, 1'b0);
        res.second = make_result({6'b0, supp[9:0]} + LowSurr, ST_OK, 3'd0, 1'b1);
      end
    end else if (last_in_stream) begin
      expected_length_next = '0;
      bytes_seen_next      = '0;
      accumulator_next     = '0;
      res.count            = 2'd1;
      res.first            = make_result(Replacement, ST_TRUNC, 3'd0, 1'b1);
    end else begin
      bytes_seen_next  = seen_inc;
      accumulator_next = acc_shift;
    end
  end

  always_comb begin
    push = res;
    if (!accept) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= '0;
      bytes_seen      <= '0;
      accumulator     <= '0;
    end else if (accept) begin
      expected_length <= expected_length_next;
      bytes_seen      <= bytes_seen_next;
      accumulator     <= accumulator_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/u8u16_outq.sv @@
// Four-entry result queue, takes up to two results per cycle, sends one while ready is high.
`default_nettype none
module u8u16_outq (
  input  logic                clk,
  input  logic                rst,
  input  u8u16_pkg::push_t    push,
  output logic                room,
  output logic                valid,
  input  logic                ready,
  output u8u16_pkg::result_t  head
);
  import u8u16_pkg::*;

  result_t    q [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic       pop;

  assign valid      = count != 3'd0;
  assign pop        = valid && ready;
  assign room       = count <= 3'd2;
  assign head       = q[rd_ptr];
  assign count_next = count + {1'b0, push.count} - {2'b0, pop};

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      q[wr_ptr + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/utf8_to_utf16_decoder.sv @@
// Top level of the UTF-8 to UTF-16 decoder.
//
//  channel  dir  beat contents
//  -------  ---  ------------------------------------------------------
//  bytes    in   byte_value[7:0], last_in_stream
//  units    out  code_unit[15:0], status[1:0], bad_length[2:0], last_of_run
//
// One byte per cycle; the byte is decoded the cycle it is taken and its
// results sit in a four-entry queue. A supplementary character takes at least
// four bytes and gives two beats, so the single output port keeps up with one
// byte per cycle. bytes.ready is high while the queue holds two or fewer
// units, so stalls on units backpressure bytes once three beats are queued.
// Reset (synchronous, rst high) closes any open sequence and empties the queue.
`default_nettype none
module utf8_to_utf16_decoder (
  input  logic                clk,
  input  logic                rst,
  u8u16_byte_if.sink          bytes,
  u8u16_unit_if.source        units
);
  import u8u16_pkg::*;

  push_t   push;
  result_t head;
  logic    room;
  logic    accept;

  assign bytes.ready = room;
  assign accept      = bytes.valid && room;

  u8u16_decode u_decode (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .byte_value     (bytes.byte_value),
    .last_in_stream (bytes.last_in_stream),
    .push           (push)
  );

  u8u16_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .valid (units.valid),
    .ready (units.ready),
    .head  (head)
  );

  assign units.code_unit   = head.code_unit;
  assign units.status      = head.status;
  assign units.bad_length  = head.bad_length;
  assign units.last_of_run = head.last_of_run;

endmodule
`default_nettype wire

@@ sv/u8u16_checker.sv @@
// Port-level assertions for the decoder and their bind to the top level.
`default_nettype none
module u8u16_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] code_unit,
  input logic [1:0]  status,
  input logic [2:0]  bad_length,
  input logic        last_of_run
);
  import u8u16_pkg::*;

  logic hi_open;
  assign hi_open = status == ST_OK && !last_of_run &&
                   code_unit[15:10] == 6'b110110;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("units valid after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("bytes stalled with empty queue");

  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && hi_open |=>
      out_valid && last_of_run && code_unit[15:10] == 6'b110111)
    else $error("high surrogate not followed by low surrogate");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(code_unit) && $stable(status) && $stable(bad_length))
    else $error("stalled unit beat changed");

  a_error_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> code_unit == Replacement && last_of_run)
    else $error("error beat without replacement unit");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (bytes.ready),
  .out_valid   (units.valid),
  .out_ready   (units.ready),
  .code_unit   (units.code_unit),
  .status      (units.status),
  .bad_length  (units.bad_length),
  .last_of_run (units.last_of_run)
);
`default_nettype wire
